// ===== hw/rtl/riex_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riex_pkg
// Shared types and instruction encodings for the integer execute unit.
// ----------------------------------------------------------------------------
package riex_pkg;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [4:0]  EXIT_REG   = 5'd2;
  localparam logic [31:0] EXIT_CODE  = 32'd10;
  localparam logic [31:0] START_RST  = 32'h0040_0000;
  localparam logic [31:0] BASE_RST   = 32'h1000_0000;

  // Configuration register indexes
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_BASE  = 1'b1;

  // Instruction class seen by the controller
  typedef enum logic [2:0] {
    CLS_SIMPLE,
    CLS_MUL,
    CLS_DIV,
    CLS_LOAD,
    CLS_STORE
  } cls_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MULFIX,
    ST_DIV,
    ST_DIVFIX,
    ST_MEMRD,
    ST_MEMCAP,
    ST_MEMWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic exec;
    logic mul_fix;
    logic div_step;
    logic div_fix;
    logic mem_rd;
    logic mem_cap;
    logic mem_wr;
    logic commit;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    cls_t kind;
    logic div_done;
    logic last_byte;
  } stat_t;

endpackage

// ===== hw/rtl/riex_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riex_if
// Valid/ready channels for instruction words and execution results.
// ----------------------------------------------------------------------------
interface riex_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface riex_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_we;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [31:0] hi_value;
  logic [31:0] lo_value;
  logic        halted;

  modport source (output valid, output next_pc, output reg_we, output reg_index,
                  output reg_value, output hi_value, output lo_value,
                  output halted, input ready);
  modport sink   (input valid, input next_pc, input reg_we, input reg_index,
                  input reg_value, input hi_value, input lo_value,
                  input halted, output ready);
endinterface

// ===== hw/rtl/riex_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riex_ctrl
// Sequencer: steps each instruction through read, execute, multiply fixup,
// divide iterations and fixup or byte-serial memory access, and write-back.
// ----------------------------------------------------------------------------
module riex_ctrl
  import riex_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    out_vld_nxt = out_vld_r && !out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.kind)
          CLS_MUL:   state_nxt = ST_MULFIX;
          CLS_DIV:   state_nxt = ST_DIV;
          CLS_LOAD:  state_nxt = ST_MEMRD;
          CLS_STORE: state_nxt = ST_MEMWR;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_MULFIX: begin
        cmd.mul_fix = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = ST_DIVFIX;
      end
      ST_DIVFIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_MEMRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_MEMCAP;
      end
      ST_MEMCAP: begin
        cmd.mem_cap = 1'b1;
        state_nxt   = stat.last_byte ? ST_DONE : ST_MEMRD;
      end
      ST_MEMWR: begin
        cmd.mem_wr = 1'b1;
        if (stat.last_byte) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_vld_r || out_ready) begin
          cmd.commit  = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ===== hw/rtl/riex_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riex_dpath
// Datapath: register file, HI/LO, PC, ALU, multiplier, radix-2 divider,
// byte data memory, configuration registers and the result register.
// ----------------------------------------------------------------------------
module riex_dpath
  import riex_pkg::*;
#(
  parameter int DATA_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [31:0] instr_word,
  // configuration
  input  logic        cfg_wr,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] cfg_rdata,
  // result
  output logic [31:0] next_pc,
  output logic        reg_we,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic [31:0] hi_value,
  output logic [31:0] lo_value,
  output logic        halted
);

  localparam int          AW    = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam logic [31:0] DSIZE = 32'(DATA_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(DATA_BYTES - 1);

  // Architectural state
  logic [31:0] start_r, base_r, pc_r, hi_r, lo_r;
  logic        halt_r;
  logic [31:0] gpr [32];
  logic [31:0] gpr_vld_r;
  logic [7:0]  dmem [DATA_BYTES];

  // Per-instruction registers
  logic [31:0] instr_r, a_q_r, b_q_r;
  logic        a_ok_r, b_ok_r;
  logic [31:0] npc_r, val_r, addr_r, ld_acc_r;
  logic [4:0]  dst_r;
  logic        wr_r, ld_r;
  logic [63:0] prod_r;
  logic        msign_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic [4:0]  div_cnt_r;
  logic        negq_r, negr_r;
  logic [1:0]  bcnt_r;
  logic [7:0]  mq_r;
  logic        mwin_r;
  logic [AW-1:0] clr_cnt_r;

  // Decode
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa, rt_sel;
  logic [15:0] imm;
  logic [31:0] simm, a, b, pc4, br_tgt;
  assign op     = instr_r[31:26];
  assign fn     = instr_r[5:0];
  assign rs     = instr_r[25:21];
  assign rt     = instr_r[20:16];
  assign rd     = instr_r[15:11];
  assign sa     = instr_r[10:6];
  assign imm    = instr_r[15:0];
  assign simm   = {{16{imm[15]}}, imm};
  assign a      = a_ok_r ? a_q_r : '0;
  assign b      = b_ok_r ? b_q_r : '0;
  assign pc4    = pc_r + 32'd4;
  assign br_tgt = pc_r + {simm[29:0], 2'b00};
  // SYSCALL looks at r2 on the second read port
  assign rt_sel = (op == OP_SPECIAL && fn == FN_SYSCALL) ? EXIT_REG : rt;

  // Execute stage
  cls_t        kind;
  logic [31:0] ex_val, ex_npc;
  logic [4:0]  ex_dst;
  logic        ex_wr, ex_ld, ex_mthi, ex_mtlo, ex_halt;
  logic [1:0]  nb_m1;

  always_comb begin
    kind    = CLS_SIMPLE;
    ex_val  = '0;
    ex_dst  = rd;
    ex_wr   = 1'b0;
    ex_ld   = 1'b0;
    ex_npc  = pc4;
    ex_mthi = 1'b0;
    ex_mtlo = 1'b0;
    ex_halt = 1'b0;
    if (halt_r) begin
      ex_npc = pc_r;
    end else if (op == OP_SPECIAL) begin
      unique case (fn)
        FN_SLL: begin ex_val = b << sa; ex_wr = 1'b1; end
        FN_SRL: begin ex_val = b >> sa; ex_wr = 1'b1; end
        FN_SRA: begin ex_val = 32'($signed(b) >>> sa); ex_wr = 1'b1; end
        FN_SYSCALL: ex_halt = (b == EXIT_CODE);
        FN_MFHI: begin ex_val = hi_r; ex_wr = 1'b1; end
        FN_MTHI: ex_mthi = 1'b1;
        FN_MFLO: begin ex_val = lo_r; ex_wr = 1'b1; end
        FN_MTLO: ex_mtlo = 1'b1;
        FN_MULT, FN_MULTU: kind = CLS_MUL;
        FN_DIV, FN_DIVU: if (b != '0) kind = CLS_DIV;
        FN_ADD, FN_ADDU: begin ex_val = a + b; ex_wr = 1'b1; end
        FN_SUB, FN_SUBU: begin ex_val = a - b; ex_wr = 1'b1; end
        FN_AND: begin ex_val = a & b;    ex_wr = 1'b1; end
        FN_OR:  begin ex_val = a | b;    ex_wr = 1'b1; end
        FN_XOR: begin ex_val = a ^ b;    ex_wr = 1'b1; end
        FN_NOR: begin ex_val = ~(a | b); ex_wr = 1'b1; end
        FN_SLT: begin ex_val = {31'b0, $signed(a) < $signed(b)}; ex_wr = 1'b1; end
        default: ;
      endcase
    end else begin
      ex_dst = rt;
      unique case (op)
        OP_BEQ:  if (a == b) ex_npc = br_tgt;
        OP_BNE:  if (a != b) ex_npc = br_tgt;
        OP_BLEZ: if (a[31] || a == '0) ex_npc = br_tgt;
        OP_ADDI, OP_ADDIU: begin ex_val = a + simm; ex_wr = 1'b1; end
        OP_SLTI: begin ex_val = {31'b0, $signed(a) < $signed(simm)}; ex_wr = 1'b1; end
        OP_ANDI: begin ex_val = a & {16'b0, imm}; ex_wr = 1'b1; end
        OP_ORI:  begin ex_val = a | {16'b0, imm}; ex_wr = 1'b1; end
        OP_XORI: begin ex_val = a ^ {16'b0, imm}; ex_wr = 1'b1; end
        OP_LUI:  begin ex_val = {imm, 16'b0}; ex_wr = 1'b1; end
        OP_LB, OP_LH, OP_LW: begin kind = CLS_LOAD; ex_wr = 1'b1; ex_ld = 1'b1; end
        OP_SB, OP_SH, OP_SW: kind = CLS_STORE;
        default: ;
      endcase
    end
  end

  // Bytes per memory access, minus one
  always_comb begin
    unique case (op)
      OP_LH, OP_SH: nb_m1 = 2'd1;
      OP_LW, OP_SW: nb_m1 = 2'd3;
      default:      nb_m1 = 2'd0;
    endcase
  end

  // Memory byte address and window check
  logic [31:0] byte_addr, byte_off;
  logic        in_win;
  logic [7:0]  st_byte;
  assign byte_addr = addr_r + {30'b0, bcnt_r};
  assign byte_off  = byte_addr - base_r;
  assign in_win    = byte_off < DSIZE;
  assign st_byte   = 8'(b >> {bcnt_r, 3'b000});

  // Divider step (restoring, one quotient bit per cycle)
  logic [32:0] rem_sh;
  logic [33:0] rem_diff;
  assign rem_sh   = {rem_r, quo_r[31]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs_r};

  // Load formatting and commit value
  logic [31:0] ld_val, cm_val;
  logic        cm_we;
  always_comb begin
    unique case (op)
      OP_LB:   ld_val = {{24{ld_acc_r[7]}}, ld_acc_r[7:0]};
      OP_LH:   ld_val = {{16{ld_acc_r[15]}}, ld_acc_r[15:0]};
      default: ld_val = ld_acc_r;
    endcase
  end
  assign cm_we  = wr_r && (dst_r != '0);
  assign cm_val = ld_r ? ld_val : val_r;

  assign stat.clr_done  = (clr_cnt_r == CLR_LAST);
  assign stat.kind      = kind;
  assign stat.div_done  = (div_cnt_r == 5'd31);
  assign stat.last_byte = (bcnt_r == nb_m1);

  assign cfg_rdata = (cfg_idx == CFG_BASE) ? base_r : start_r;

  // Control-like state: config, PC, halt, HI/LO, valid bits, clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= START_RST;
      base_r    <= BASE_RST;
      pc_r      <= START_RST;
      halt_r    <= 1'b0;
      hi_r      <= '0;
      lo_r      <= '0;
      gpr_vld_r <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_wr) begin
        if (cfg_idx == CFG_START) begin
          start_r <= cfg_wdata;
          pc_r    <= cfg_wdata;
        end else begin
          base_r <= cfg_wdata;
        end
      end
      if (cmd.exec) begin
        if (ex_halt) halt_r <= 1'b1;
        if (ex_mthi) hi_r <= a;
        if (ex_mtlo) lo_r <= a;
      end
      if (cmd.mul_fix) begin
        hi_r <= prod_r[63:32] - (msign_r && a[31] ? b : '0)
                              - (msign_r && b[31] ? a : '0);
        lo_r <= prod_r[31:0];
      end
      if (cmd.div_fix) begin
        lo_r <= negq_r ? (32'd0 - quo_r) : quo_r;
        hi_r <= negr_r ? (32'd0 - rem_r) : rem_r;
      end
      if (cmd.commit) begin
        pc_r <= npc_r;
        if (cm_we) gpr_vld_r[dst_r] <= 1'b1;
      end
    end
  end

  // Register file: written at commit, read with registered data
  always_ff @(posedge clk) begin
    if (cmd.commit && cm_we) gpr[dst_r] <= cm_val;
    if (cmd.rd_issue) begin
      a_q_r  <= gpr[rs];
      b_q_r  <= gpr[rt_sel];
      a_ok_r <= gpr_vld_r[rs];
      b_ok_r <= gpr_vld_r[rt_sel];
    end
  end

  // Data memory: clearing pass or byte store; registered byte read
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      dmem[clr_cnt_r] <= '0;
    end else if (cmd.mem_wr && in_win) begin
      dmem[byte_off[AW-1:0]] <= st_byte;
    end
    if (cmd.mem_rd) begin
      mq_r   <= dmem[byte_off[AW-1:0]];
      mwin_r <= in_win;
    end
  end

  // Per-instruction payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) instr_r <= instr_word;
    if (cmd.exec) begin
      npc_r    <= ex_npc;
      val_r    <= ex_val;
      dst_r    <= ex_dst;
      wr_r     <= ex_wr;
      ld_r     <= ex_ld;
      addr_r   <= a + simm;
      bcnt_r   <= '0;
      ld_acc_r <= '0;
      prod_r   <= a * b;
      msign_r  <= (fn == FN_MULT);
      // divider operands as magnitudes
      rem_r     <= '0;
      div_cnt_r <= '0;
      if (fn == FN_DIV) begin
        quo_r  <= a[31] ? (32'd0 - a) : a;
        dvs_r  <= b[31] ? (32'd0 - b) : b;
        negq_r <= a[31] ^ b[31];
        negr_r <= a[31];
      end else begin
        quo_r  <= a;
        dvs_r  <= b;
        negq_r <= 1'b0;
        negr_r <= 1'b0;
      end
    end
    if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!rem_diff[33]) begin
        rem_r <= rem_diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
    if (cmd.mem_cap) begin
      ld_acc_r[{bcnt_r, 3'b000} +: 8] <= mwin_r ? mq_r : 8'h00;
      bcnt_r <= bcnt_r + 1'b1;
    end
    if (cmd.mem_wr) bcnt_r <= bcnt_r + 1'b1;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      next_pc   <= npc_r;
      reg_we    <= cm_we;
      reg_index <= cm_we ? dst_r : '0;
      reg_value <= cm_we ? cm_val : '0;
      hi_value  <= hi_r;
      lo_value  <= lo_r;
      halted    <= halt_r;
    end
  end

endmodule

// ===== hw/rtl/risc_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risc_integer_execute_unit
// Multicycle executor for a MIPS32 integer subset, one instruction per transfer.
// ----------------------------------------------------------------------------
// One instruction word is taken per input transfer and one result per output
// transfer. Each instruction runs on a controller stepping a shared datapath:
// ALU, branch and HI/LO moves need no extra step; MULT and MULTU add a fixup
// (one 32x32 product plus a signed correction), DIV and DIVU a
// one-bit-per-cycle divider and a fixup, and loads and stores go byte by byte,
// since the data memory has a single byte-wide port. After reset all DATA_BYTES
// bytes of data memory are cleared, one byte per cycle, before the first
// instruction is accepted; configuration writes are taken during that pass.
// A finished result sits in an output register while the next word is taken.
module risc_integer_execute_unit
  import riex_pkg::*;
#(
  parameter int DATA_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  riex_instr_if.sink    in_chan,
  riex_result_if.source out_chan,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  riex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  riex_dpath #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .instr_word (in_chan.instr_word),
    .cfg_wr     (cfg_wr),
    .cfg_idx    (cfg_paddr[2]),
    .cfg_wdata  (cfg_pwdata),
    .cfg_rdata  (cfg_prdata),
    .next_pc    (out_chan.next_pc),
    .reg_we     (out_chan.reg_we),
    .reg_index  (out_chan.reg_index),
    .reg_value  (out_chan.reg_value),
    .hi_value   (out_chan.hi_value),
    .lo_value   (out_chan.lo_value),
    .halted     (out_chan.halted)
  );

endmodule

// ===== hw/rtl/riex_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riex_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module riex_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_reg_we,
  input logic [4:0]  out_reg_index,
  input logic [31:0] out_reg_value,
  input logic        out_halted
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Right after reset the memory clear pass blocks input
  a_clear_block: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_ready)
    else $error("input taken during memory clear");

  // No register write reported once halted
  a_halt_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> !out_reg_we)
    else $error("register write while halted");

  // Write fields are zero without a write, and r0 is never reported
  a_wr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reg_we ? (out_reg_index != 5'd0)
                              : (out_reg_index == 5'd0 && out_reg_value == 32'd0)))
    else $error("inconsistent register write fields");

endmodule

bind risc_integer_execute_unit riex_checker u_riex_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_reg_we    (out_chan.reg_we),
  .out_reg_index (out_chan.reg_index),
  .out_reg_value (out_chan.reg_value),
  .out_halted    (out_chan.halted)
);

// ===== verif/riex_trace_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riex_trace_checker
// Watches the instruction, result and register channels of the execute unit,
// runs its own copy of the architectural state for every accepted word and
// compares each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module riex_trace_checker
  import riex_pkg::*;
#(
  parameter int DATA_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  riex_instr_if       in_chan,
  riex_result_if      out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_we;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        halted;
  } exec_result_t;

  // Architectural state mirror
  logic [31:0] start_q, base_q, hi_q, lo_q, pc_q;
  logic [31:0] gpr [32];
  logic        halt_q;
  logic [7:0]  mem_bytes [DATA_BYTES];

  exec_result_t result_q[$];

  function automatic logic [31:0] load_byte(logic [31:0] addr);
    logic [31:0] off;
    off = addr - base_q;
    return (off < DATA_BYTES) ? {24'b0, mem_bytes[off]} : 32'b0;
  endfunction

  function automatic void store_byte(logic [31:0] addr, logic [7:0] v);
    logic [31:0] off;
    off = addr - base_q;
    if (off < DATA_BYTES) mem_bytes[off] = v;
  endfunction

  // Executes one word on the mirror and returns what the unit must report
  function automatic exec_result_t execute_word(logic [31:0] w);
    exec_result_t res;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa, dst;
    logic [31:0] imm, simm, a, b, npc, addr, val, ma, mb, q, r;
    logic [63:0] p;
    logic        wr;
    op = w[31:26]; fn = w[5:0];
    rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6];
    imm = {16'b0, w[15:0]};
    simm = {{16{w[15]}}, w[15:0]};
    a = gpr[rs]; b = gpr[rt];
    npc = pc_q + 32'd4;
    addr = a + simm;
    dst = '0; val = '0; wr = 1'b0;
    if (halt_q) begin
      res = '{pc_q, 1'b0, 5'd0, 32'd0, hi_q, lo_q, 1'b1};
      return res;
    end
    if (op == OP_SPECIAL) begin
      case (fn)
        FN_SLL: begin dst = rd; val = b << sa; wr = 1; end
        FN_SRL: begin dst = rd; val = b >> sa; wr = 1; end
        FN_SRA: begin dst = rd; val = $signed(b) >>> sa; wr = 1; end
        FN_SYSCALL: if (gpr[EXIT_REG] == EXIT_CODE) halt_q = 1'b1;
        FN_MFHI: begin dst = rd; val = hi_q; wr = 1; end
        FN_MTHI: hi_q = a;
        FN_MFLO: begin dst = rd; val = lo_q; wr = 1; end
        FN_MTLO: lo_q = a;
        FN_MULT: begin
          p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          hi_q = p[63:32]; lo_q = p[31:0];
        end
        FN_MULTU: begin
          p = {32'b0, a} * {32'b0, b};
          hi_q = p[63:32]; lo_q = p[31:0];
        end
        FN_DIV: if (b != 0) begin
          // magnitudes first, then signs: quotient toward zero
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb; r = ma % mb;
          lo_q = (a[31] != b[31]) ? -q : q;
          hi_q = a[31] ? -r : r;
        end
        FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
        FN_ADD, FN_ADDU: begin dst = rd; val = a + b; wr = 1; end
        FN_SUB, FN_SUBU: begin dst = rd; val = a - b; wr = 1; end
        FN_AND: begin dst = rd; val = a & b; wr = 1; end
        FN_OR:  begin dst = rd; val = a | b; wr = 1; end
        FN_XOR: begin dst = rd; val = a ^ b; wr = 1; end
        FN_NOR: begin dst = rd; val = ~(a | b); wr = 1; end
        FN_SLT: begin dst = rd; val = ($signed(a) < $signed(b)) ? 1 : 0; wr = 1; end
        default: ;
      endcase
    end else begin
      case (op)
        OP_BEQ:  if (a == b) npc = pc_q + (simm << 2);
        OP_BNE:  if (a != b) npc = pc_q + (simm << 2);
        OP_BLEZ: if (a[31] || a == 0) npc = pc_q + (simm << 2);
        OP_ADDI, OP_ADDIU: begin dst = rt; val = a + simm; wr = 1; end
        OP_SLTI: begin dst = rt; val = ($signed(a) < $signed(simm)) ? 1 : 0; wr = 1; end
        OP_ANDI: begin dst = rt; val = a & imm; wr = 1; end
        OP_ORI:  begin dst = rt; val = a | imm; wr = 1; end
        OP_XORI: begin dst = rt; val = a ^ imm; wr = 1; end
        OP_LUI:  begin dst = rt; val = imm << 16; wr = 1; end
        OP_LB: begin
          val = load_byte(addr);
          val = {{24{val[7]}}, val[7:0]};
          dst = rt; wr = 1;
        end
        OP_LH: begin
          val = load_byte(addr) | (load_byte(addr + 1) << 8);
          val = {{16{val[15]}}, val[15:0]};
          dst = rt; wr = 1;
        end
        OP_LW: begin
          val = load_byte(addr) | (load_byte(addr + 1) << 8) |
                (load_byte(addr + 2) << 16) | (load_byte(addr + 3) << 24);
          dst = rt; wr = 1;
        end
        OP_SB: store_byte(addr, b[7:0]);
        OP_SH: begin store_byte(addr, b[7:0]); store_byte(addr + 1, b[15:8]); end
        OP_SW: begin
          store_byte(addr, b[7:0]);      store_byte(addr + 1, b[15:8]);
          store_byte(addr + 2, b[23:16]); store_byte(addr + 3, b[31:24]);
        end
        default: ;
      endcase
    end
    // r0 writes are dropped and reported as no write
    if (wr && dst != 0) gpr[dst] = val;
    else begin wr = 0; dst = 0; val = 0; end
    pc_q = npc;
    res = '{npc, wr, dst, val, hi_q, lo_q, halt_q};
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    exec_result_t exp_r;
    if (!rst_n) begin
      start_q = START_RST; base_q = BASE_RST; pc_q = START_RST;
      hi_q = 0; lo_q = 0; halt_q = 0;
      for (int i = 0; i < 32; i++) gpr[i] = 0;
      for (int i = 0; i < DATA_BYTES; i++) mem_bytes[i] = 0;
      result_q.delete();
      mismatches = 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == CFG_START) begin
          start_q = cfg_pwdata; pc_q = cfg_pwdata;
        end else begin
          base_q = cfg_pwdata;
        end
      end
      // result transfers are checked before new words are predicted
      if (out_chan.valid && out_chan.ready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected (next_pc 0x%08h)",
                   $time, out_chan.next_pc);
        end else begin
          exp_r = result_q.pop_front();
          check_field("next_pc", exp_r.next_pc, out_chan.next_pc);
          check_field("reg_we", exp_r.reg_we, out_chan.reg_we);
          check_field("reg_index", exp_r.reg_index, out_chan.reg_index);
          check_field("reg_value", exp_r.reg_value, out_chan.reg_value);
          check_field("hi_value", exp_r.hi_value, out_chan.hi_value);
          check_field("lo_value", exp_r.lo_value, out_chan.lo_value);
          check_field("halted", exp_r.halted, out_chan.halted);
        end
      end
      if (in_chan.valid && in_chan.ready)
        result_q.push_back(execute_word(in_chan.instr_word));
    end
    pending <= result_q.size();
  end

endmodule

// ===== verif/tb_risc_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_risc_integer_execute_unit
// Drives instruction words and register writes into the execute unit.
// ----------------------------------------------------------------------------
// A directed program covers operand extremes, every operation but ADDU and corner
// cases (wraparound, r0, divide by zero, window start, branches). Random phases
// under several start/base settings send mostly well-formed words, some address
// setup plus memory access, with random stalls on both channels but in the last.
module tb_risc_integer_execute_unit;
  import riex_pkg::*;

  localparam int          MEM_BYTES  = 4096;
  localparam int          WDOG_LIMIT = 20000;
  localparam int          PHASE_ITEMS = 200;
  localparam logic [5:0]  OP_REGIMM  = 6'h01;
  localparam logic [5:0]  FN_UNUSED  = 6'h3F;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        quiet;
  int          stall_cnt;
  int          idle_cycles;
  int          items_sent;
  int          mismatches;
  int          pending;

  riex_instr_if  instr_if ();
  riex_result_if result_if ();

  risc_integer_execute_unit #(.DATA_BYTES(MEM_BYTES)) uut (
    .clk(clk), .rst_n(rst_n), .in_chan(instr_if), .out_chan(result_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  riex_trace_checker #(.DATA_BYTES(MEM_BYTES)) checker_i (
    .clk(clk), .rst_n(rst_n), .in_chan(instr_if), .out_chan(result_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
      stall_cnt <= 0;
    end else if (quiet) begin
      result_if.ready <= 1'b1;
    end else if (stall_cnt > 0) begin
      result_if.ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      result_if.ready <= 1'b0;
      stall_cnt <= $urandom_range(0, 11);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((instr_if.valid && instr_if.ready) || (result_if.valid && result_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("** risc_integer_execute_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sa);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  task automatic cfg_write(logic idx, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // One word transfer, with an optional random gap before it
  task automatic send_word(logic [31:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_if.valid <= 1'b1;
    instr_if.instr_word <= w;
    do @(posedge clk); while (!instr_if.ready);
    items_sent++;
  endtask

  task automatic load_const(logic [4:0] r, logic [31:0] v);
    send_word(enc_i(OP_LUI, 5'd0, r, v[31:16]));
    send_word(enc_i(OP_ORI, r, r, v[15:0]));
  endtask

  // Sender holds off until every outstanding result has been transferred
  task automatic drain();
    instr_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_item(logic [31:0] base);
    int          kind;
    logic [31:0] w, addr;
    logic [4:0]  rb;
    logic [5:0]  op, fn;
    logic [15:0] off;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // raw noise, but never an accidental exit
      w = $urandom;
      if (w[31:26] == OP_SPECIAL && w[5:0] == FN_SYSCALL) w[5:0] = FN_SLL;
      send_word(w);
    end else if (kind < 40) begin
      // pointer setup then a memory access, sometimes at the window edges
      case ($urandom_range(0, 9))
        0: addr = base - $urandom_range(1, 6);
        1: addr = base + MEM_BYTES - $urandom_range(1, 6);
        default: addr = base + $urandom_range(0, MEM_BYTES - 1);
      endcase
      rb = 5'($urandom_range(1, 31));
      load_const(rb, addr);
      case ($urandom_range(0, 5))
        0: op = OP_LB;
        1: op = OP_LH;
        2: op = OP_LW;
        3: op = OP_SB;
        4: op = OP_SH;
        default: op = OP_SW;
      endcase
      off = 16'($urandom_range(0, 15) - 8);
      send_word(enc_i(op, rb, 5'($urandom_range(0, 31)), off));
    end else if (kind < 50) begin
      case ($urandom_range(0, 2))
        0: op = OP_BEQ;
        1: op = OP_BNE;
        default: op = OP_BLEZ;
      endcase
      send_word(enc_i(op, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      16'($urandom)));
    end else if (kind < 58) begin
      load_const(5'($urandom_range(1, 31)), $urandom_range(0, 1) ? $urandom :
                 ($urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF));
    end else if (kind < 75) begin
      case ($urandom_range(0, 6))
        0: op = OP_ADDI;
        1: op = OP_ADDIU;
        2: op = OP_SLTI;
        3: op = OP_ANDI;
        4: op = OP_ORI;
        5: op = OP_XORI;
        default: op = OP_LUI;
      endcase
      send_word(enc_i(op, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      16'($urandom)));
    end else begin
      case ($urandom_range(0, 19))
        0: fn = FN_SLL;   1: fn = FN_SRL;   2: fn = FN_SRA;   3: fn = FN_MFHI;
        4: fn = FN_MTHI;  5: fn = FN_MFLO;  6: fn = FN_MTLO;  7: fn = FN_MULT;
        8: fn = FN_MULTU; 9: fn = FN_DIV;   10: fn = FN_DIVU; 11: fn = FN_ADD;
        12: fn = FN_ADDU; 13: fn = FN_SUB;  14: fn = FN_SUBU; 15: fn = FN_AND;
        16: fn = FN_OR;   17: fn = FN_XOR;  18: fn = FN_NOR;  default: fn = FN_SLT;
      endcase
      send_word(enc_r(fn, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))));
    end
  endtask

  task automatic random_phase(logic [31:0] start, logic [31:0] base);
    int target;
    cfg_write(CFG_START, start);
    cfg_write(CFG_BASE, base);
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_item(base);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    instr_if.valid = 1'b0;
    instr_if.instr_word = '0;
    result_if.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    idle_cycles = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed program at the reset settings
    cfg_write(CFG_START, START_RST);
    cfg_write(CFG_BASE, BASE_RST);
    send_word(enc_i(OP_ADDIU, 5'd0, 5'd1, 16'hFFFF));   // r1 = -1
    send_word(enc_i(OP_LUI, 5'd0, 5'd3, 16'h8000));     // r3 = most negative
    send_word(enc_i(OP_ADDI, 5'd3, 5'd4, 16'h8000));    // wraps
    send_word(enc_r(FN_ADD, 5'd3, 5'd3, 5'd5, 5'd0));   // wraps to zero
    send_word(enc_r(FN_SUB, 5'd3, 5'd1, 5'd5, 5'd0));
    send_word(enc_r(FN_SUBU, 5'd1, 5'd3, 5'd0, 5'd0));  // r0 write dropped
    send_word(enc_r(FN_AND, 5'd1, 5'd3, 5'd7, 5'd0));
    send_word(enc_r(FN_OR, 5'd1, 5'd3, 5'd7, 5'd0));
    send_word(enc_r(FN_XOR, 5'd1, 5'd3, 5'd7, 5'd0));
    send_word(enc_r(FN_NOR, 5'd0, 5'd0, 5'd8, 5'd0));
    send_word(enc_r(FN_SLT, 5'd3, 5'd1, 5'd9, 5'd0));
    send_word(enc_i(OP_SLTI, 5'd1, 5'd10, 16'h0001));
    send_word(enc_i(OP_ANDI, 5'd1, 5'd11, 16'hFFFF));
    send_word(enc_i(OP_ORI, 5'd0, 5'd12, 16'hFFFF));
    send_word(enc_i(OP_XORI, 5'd1, 5'd13, 16'h8000));
    send_word(enc_r(FN_SLL, 5'd0, 5'd1, 5'd14, 5'd31));
    send_word(enc_r(FN_SRL, 5'd0, 5'd3, 5'd15, 5'd31));
    send_word(enc_r(FN_SRA, 5'd0, 5'd3, 5'd16, 5'd31));
    send_word(enc_r(FN_MULT, 5'd1, 5'd3, 5'd0, 5'd0));
    send_word(enc_r(FN_MULTU, 5'd1, 5'd1, 5'd0, 5'd0));
    send_word(enc_r(FN_DIV, 5'd3, 5'd1, 5'd0, 5'd0));   // most negative by -1
    send_word(enc_r(FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0));   // by zero: HI/LO kept
    send_word(enc_r(FN_DIVU, 5'd1, 5'd3, 5'd0, 5'd0));
    send_word(enc_r(FN_DIV, 5'd4, 5'd12, 5'd0, 5'd0));  // positive dividend and divisor
    send_word(enc_r(FN_MFHI, 5'd0, 5'd0, 5'd17, 5'd0));
    send_word(enc_r(FN_MFLO, 5'd0, 5'd0, 5'd18, 5'd0));
    send_word(enc_r(FN_MTHI, 5'd3, 5'd0, 5'd0, 5'd0));
    send_word(enc_r(FN_MTLO, 5'd1, 5'd0, 5'd0, 5'd0));
    load_const(5'd6, BASE_RST);
    send_word(enc_i(OP_SW, 5'd6, 5'd3, 16'h0000));
    send_word(enc_i(OP_SH, 5'd6, 5'd1, 16'h0004));
    send_word(enc_i(OP_SB, 5'd6, 5'd1, 16'h0007));
    send_word(enc_i(OP_SW, 5'd6, 5'd1, 16'hFFFE));      // straddles window start
    send_word(enc_i(OP_LB, 5'd6, 5'd19, 16'h0003));
    send_word(enc_i(OP_LH, 5'd6, 5'd20, 16'h0003));     // unaligned
    send_word(enc_i(OP_LW, 5'd6, 5'd21, 16'h0005));
    send_word(enc_i(OP_LW, 5'd6, 5'd22, 16'hFFFE));     // partly outside
    send_word(enc_i(OP_BEQ, 5'd1, 5'd1, 16'hFFFE));
    send_word(enc_i(OP_BNE, 5'd1, 5'd3, 16'h7FFF));
    send_word(enc_i(OP_BLEZ, 5'd3, 5'd0, 16'h8000));
    send_word(enc_i(OP_BLEZ, 5'd0, 5'd0, 16'h0004));
    send_word(enc_i(OP_BLEZ, 5'd11, 5'd0, 16'h0004));   // positive: not taken
    send_word(enc_i(OP_REGIMM, 5'd1, 5'd0, 16'h0010));
    send_word(enc_r(FN_UNUSED, 5'd1, 5'd1, 5'd1, 5'd1));
    send_word(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0)); // r2 is not the exit code
    drain();

    // Random phases under several settings, extremes included
    random_phase(32'h0000_0000, 32'h0000_0000);
    random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    quiet = 1'b1;
    random_phase($urandom, 32'h7FFF_F800);

    // Exit syscall, then words that must change nothing
    send_word(enc_i(OP_ADDIU, 5'd0, EXIT_REG, EXIT_CODE[15:0]));
    send_word(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
    send_word(enc_i(OP_ADDIU, 5'd0, 5'd5, 16'h1234));
    send_word(enc_r(FN_MTHI, 5'd1, 5'd0, 5'd0, 5'd0));
    send_word(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0010));
    drain();

    if (mismatches == 0)
      $display("** risc_integer_execute_unit: PASSED **");
    else
      $display("** risc_integer_execute_unit: FAILED **");
    $finish;
  end

endmodule
